// ----- sv/pnpw_pkg.sv -----
// shared types, constants and the exponential root table
package pnpw_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   localparam int COORD_W    = 24;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int MAG_W      = COORD_W;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int ROOT_W     = (SUM_W + 1) / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int SQRT_STEPS = ROOT_W;

   localparam int DIST_W     = 24;
   localparam int WEIGHT_W   = 16;
   localparam int GRAD_W     = 16;
   localparam int P_W        = GRAD_W + ROOT_W;
   localparam int LOG2E_W    = 17;
   localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;
   localparam int U_W        = P_W + LOG2E_W - 24;
   localparam int FRAC_BITS  = 12;
   localparam int N_W        = U_W - FRAC_BITS;
   localparam int M_W        = 31;
   localparam int R_W        = 30;
   localparam int PROD_W     = WEIGHT_W + M_W;
   localparam int N_LIMIT    = 18;

   localparam int CSR_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRADIENT  = 2'd2;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_SCORE  = 2'd2;

   typedef logic [FRAC_BITS-1:0][R_W-1:0] rtab_type;

   typedef struct packed {
      logic              latch;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              walk_start;
      logic              sqrt_init;
      logic              sqrt_step;
      logic              exp_p;
      logic              exp_u;
      logic              frac_step;
      logic [3:0]        frac_k;
      logic              wmul;
      logic              finish;
   } cmd_type;

   typedef struct packed {
      logic             is_score;
      logic [CNT_W-1:0] cnt;
      logic             slot_free;
   } status_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] num);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] bitv;
      res = '0;
      rem = num;
      for (int i = 31; i >= 0; i--) begin
         bitv = 64'd1 << (2 * i);
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // r(k) = 2^(-2^-(k+1)) in Q.30, each the root of the one before
   function automatic rtab_type build_rtab();
      rtab_type    t;
      logic [63:0] r;
      r = 64'd1 << 29;
      for (int k = 0; k < FRAC_BITS; k++) begin
         r = isqrt64(r << 30);
         t[k] = r[R_W-1:0];
      end
      return t;
   endfunction

   localparam rtab_type RTAB = build_rtab();

endpackage

// ----- sv/particle_nearest_point_weight.sv -----
// top level: nearest stored point search and exponential particle weight
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_type, req_pos_x, req_pos_y
//  rsp      out        rsp_valid/rsp_ready  weight, observed, min_distance, count, refused
//  csr      in         csr_we               csr_index, csr_wdata
//
// clear and append: the result is registered after the start and finish states, once the output register is free
// score walks the N stored points one point per cycle through
// the store read port and distance unit, then 25 square root steps, 12 exponent steps
// result sits in an output register, so the next transfer is taken while it waits
// synchronous active high reset empties the store and loads register defaults
module particle_nearest_point_weight (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_type,
   input  logic signed [pnpw_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [pnpw_pkg::COORD_W-1:0]  req_pos_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pnpw_pkg::WEIGHT_W-1:0]        rsp_weight,
   output logic                                 rsp_observed,
   output logic [pnpw_pkg::DIST_W-1:0]          rsp_min_distance,
   output logic [8:0]                           rsp_point_count,
   output logic                                 rsp_append_refused,
   input  logic                                 csr_we,
   input  logic [pnpw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pnpw_pkg::CSR_W-1:0]           csr_wdata
);
   import pnpw_pkg::*;

   // commands from sequencer, status back from datapath
   cmd_type    cmd;
   status_type status;

   pnpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pnpw_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_weight         (rsp_weight),
      .rsp_observed       (rsp_observed),
      .rsp_min_distance   (rsp_min_distance),
      .rsp_point_count    (rsp_point_count),
      .rsp_append_refused (rsp_append_refused)
   );

endmodule

// ----- sv/pnpw_ctrl.sv -----
// sequencer for clear, append and score requests
module pnpw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pnpw_pkg::status_type   status,
   output pnpw_pkg::cmd_type      cmd
);
   import pnpw_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_START     = 4'd1;
   localparam logic [3:0] S_WALK      = 4'd2;
   localparam logic [3:0] S_DRAIN     = 4'd3;
   localparam logic [3:0] S_SQRT_INIT = 4'd4;
   localparam logic [3:0] S_SQRT      = 4'd5;
   localparam logic [3:0] S_EXP_P     = 4'd6;
   localparam logic [3:0] S_EXP_U     = 4'd7;
   localparam logic [3:0] S_FRAC      = 4'd8;
   localparam logic [3:0] S_WMUL      = 4'd9;
   localparam logic [3:0] S_FINISH    = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [4:0]       step_ff, step_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.rd_addr = idx_ff[ADDR_W-1:0];
      cmd.frac_k  = step_ff[3:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_START;
            end
         end
         S_START: begin
            idx_in = '0;
            if (status.is_score && status.cnt != '0) begin
               cmd.walk_start = 1'b1;
               state_in = S_WALK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_WALK: begin
            cmd.rd_en = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == status.cnt - 1'b1) begin
               step_in  = 5'd1;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            step_in = step_ff - 1'b1;
            if (step_ff == '0) state_in = S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            step_in  = 5'(SQRT_STEPS - 1);
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) state_in = S_EXP_P;
         end
         S_EXP_P: begin
            cmd.exp_p = 1'b1;
            state_in  = S_EXP_U;
         end
         S_EXP_U: begin
            cmd.exp_u = 1'b1;
            step_in   = 5'd1;
            state_in  = S_FRAC;
         end
         S_FRAC: begin
            cmd.frac_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(FRAC_BITS)) state_in = S_WMUL;
         end
         S_WMUL: begin
            cmd.wmul = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- sv/pnpw_dp.sv -----
// point store, distance walk, square root, exponential and result register
module pnpw_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pnpw_pkg::cmd_type                    cmd,
   output pnpw_pkg::status_type                 status,
   input  logic [1:0]                           req_type,
   input  logic signed [pnpw_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [pnpw_pkg::COORD_W-1:0]  req_pos_y,
   input  logic                                 csr_we,
   input  logic [pnpw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pnpw_pkg::CSR_W-1:0]           csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pnpw_pkg::WEIGHT_W-1:0]        rsp_weight,
   output logic                                 rsp_observed,
   output logic [pnpw_pkg::DIST_W-1:0]          rsp_min_distance,
   output logic [8:0]                           rsp_point_count,
   output logic                                 rsp_append_refused
);
   import pnpw_pkg::*;

   logic [COORD_W-1:0] mem_x [MAX_POINTS];
   logic [COORD_W-1:0] mem_y [MAX_POINTS];

   logic [DIST_W-1:0]   max_dist_ff;
   logic [WEIGHT_W-1:0] score_max_ff;
   logic [GRAD_W-1:0]   gradient_ff;

   logic [1:0]                 type_ff;
   logic signed [COORD_W-1:0]  px_ff, py_ff;
   logic [CNT_W-1:0]           cnt_ff;

   logic signed [COORD_W-1:0]  rd_x_ff, rd_y_ff;
   logic                       v1_ff, v2_ff;
   logic [SQ_W-1:0]            sqx_ff, sqy_ff;
   logic [SUM_W-1:0]           best_ff;

   logic [SUM_W:0]     num_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [ROOT_W-1:0]  root_ff;

   logic [P_W-1:0]       p_ff;
   logic [N_W-1:0]       n_ff;
   logic [FRAC_BITS-1:0] f_ff;
   logic [M_W-1:0]       m_ff;
   logic [PROD_W-1:0]    prod_ff;

   logic                 rsp_valid_ff;
   logic [WEIGHT_W-1:0]  weight_ff;
   logic                 observed_ff;
   logic [DIST_W-1:0]    mind_ff;
   logic [8:0]           count_ff;
   logic                 refused_ff;

   logic signed [DIFF_W-1:0] dx, dy;
   logic [MAG_W-1:0]         ax, ay;
   logic [SUM_W-1:0]         sum;
   logic [REM_W-1:0]         rem_sh, trial;
   logic [P_W+LOG2E_W-1:0]   pu;
   logic [M_W+R_W-1:0]       mr;
   logic                     full, observed;
   logic [5:0]               wshift;
   logic [PROD_W-1:0]        shifted;

   assign status.is_score  = (type_ff == REQ_SCORE);
   assign status.cnt       = cnt_ff;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      dx  = DIFF_W'(rd_x_ff) - DIFF_W'(px_ff);
      dy  = DIFF_W'(rd_y_ff) - DIFF_W'(py_ff);
      ax  = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      ay  = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      sum = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      rem_sh = {rem_ff[REM_W-3:0], num_ff[SUM_W:SUM_W-1]};
      trial  = {1'b0, root_ff, 2'b01};
      pu  = P_W'(p_ff) * LOG2E_Q16;
      mr  = m_ff * RTAB[cmd.frac_k - 1'b1];
      full = (cnt_ff >= CNT_W'(MAX_POINTS));
      observed = ({1'b0, max_dist_ff} >= (DIST_W + 1)'(root_ff));
      wshift  = 6'd30 + 6'(n_ff[4:0]);
      shifted = prod_ff >> wshift;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff  <= 24'd2560;
         score_max_ff <= 16'd40960;
         gradient_ff  <= 16'd2048;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_DIST:  max_dist_ff  <= csr_wdata;
            CSR_SCORE_MAX: score_max_ff <= csr_wdata[WEIGHT_W-1:0];
            CSR_GRADIENT:  gradient_ff  <= csr_wdata[GRAD_W-1:0];
            default: ;
         endcase
      end
   end

   // point store
   always_ff @(posedge clock) begin
      if (cmd.finish && type_ff == REQ_APPEND && !full) begin
         mem_x[cnt_ff[ADDR_W-1:0]] <= px_ff;
         mem_y[cnt_ff[ADDR_W-1:0]] <= py_ff;
      end
      if (cmd.rd_en) begin
         rd_x_ff <= mem_x[cmd.rd_addr];
         rd_y_ff <= mem_y[cmd.rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            if (type_ff == REQ_CLEAR) cnt_ff <= '0;
            else if (type_ff == REQ_APPEND && !full) cnt_ff <= cnt_ff + 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff <= req_type;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
      end
      if (v1_ff) begin
         sqx_ff <= ax * ax;
         sqy_ff <= ay * ay;
      end
      if (cmd.walk_start) best_ff <= '1;
      else if (v2_ff && sum < best_ff) best_ff <= sum;
      if (cmd.sqrt_init) begin
         num_ff  <= {1'b0, best_ff};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         num_ff <= {num_ff[SUM_W-2:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.exp_p) p_ff <= GRAD_W'(gradient_ff) * root_ff;
      if (cmd.exp_u) begin
         n_ff <= pu[P_W+LOG2E_W-1:24+FRAC_BITS];
         f_ff <= pu[24+FRAC_BITS-1:24];
         m_ff <= M_W'(1) << 30;
      end
      if (cmd.frac_step && f_ff[4'(FRAC_BITS) - cmd.frac_k])
         m_ff <= mr[M_W+30-1:30];
      if (cmd.wmul) prod_ff <= score_max_ff * m_ff;
      if (cmd.finish) begin
         count_ff   <= 9'(type_ff == REQ_CLEAR ? '0 :
                         (type_ff == REQ_APPEND && !full) ? cnt_ff + 1'b1 : cnt_ff);
         refused_ff <= (type_ff == REQ_APPEND) && full;
         weight_ff   <= '0;
         observed_ff <= 1'b0;
         mind_ff     <= '0;
         if (type_ff == REQ_SCORE) begin
            if (cnt_ff == '0) begin
               mind_ff <= '1;
            end else begin
               mind_ff <= root_ff[ROOT_W-1] ? '1 : DIST_W'(root_ff);
               observed_ff <= observed;
               if (observed && n_ff < N_W'(N_LIMIT))
                  weight_ff <= shifted[WEIGHT_W-1:0];
            end
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_weight         = weight_ff;
   assign rsp_observed       = observed_ff;
   assign rsp_min_distance   = mind_ff;
   assign rsp_point_count    = count_ff;
   assign rsp_append_refused = refused_ff;

endmodule
